### hdl/lir_pkg.sv
// ----------------------------------------------------------------------------
// lir_pkg
// Shared widths and constants of the linear-interpolation I/Q resampler.
// ----------------------------------------------------------------------------
package lir_pkg;

   localparam int SMP_W             = 16;   // I/Q sample width
   localparam int CFG_W             = 14;   // in_per_block width, block position
   localparam int FRAC_W            = 16;   // Q0.16 weight
   localparam int OIDX_W            = 12;   // output index within a block
   localparam int DVD_W             = CFG_W + FRAC_W;
   localparam int OUT_PER_BLOCK_DEF = 2400;
   localparam int IN_PER_BLOCK_RST  = 2500;

endpackage

### hdl/lir_div.sv
// ----------------------------------------------------------------------------
// lir_div
// Step divider: (num << FRAC_W) / DIVISOR by reciprocal multiplication.
// Quotient holds the whole step (upper bits) and its Q0.16 fraction, the
// remainder holds the sub-LSB residue of the fraction.
// ----------------------------------------------------------------------------
module lir_div #(
   parameter int                          DIVISOR    = lir_pkg::OUT_PER_BLOCK_DEF,
   parameter logic [lir_pkg::DVD_W-1:0]   RESET_QUOT = '0,
   parameter int                          RESET_REM  = 0
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [lir_pkg::CFG_W-1:0]         num,
   output logic                              busy,
   output logic [lir_pkg::DVD_W-1:0]         quot,
   output logic [$clog2(DIVISOR)-1:0]        rem
);

   localparam int DVD_W = lir_pkg::DVD_W;
   localparam int REM_W = $clog2(DIVISOR);
   // ceiling reciprocal, exact for every dividend below 2^DVD_W
   localparam int SHIFT = DVD_W + REM_W;
   localparam int RCP_W = DVD_W + 1;
   localparam int PRD_W = DVD_W + RCP_W;
   localparam logic [RCP_W-1:0] RECIP =
      RCP_W'(((longint'(1) << SHIFT) + longint'(DIVISOR) - 1) / longint'(DIVISOR));
   localparam logic [DVD_W-1:0] DIV_C = DVD_W'(DIVISOR);

   typedef enum logic [2:0] {
      DIV_IDLE  = 3'b001,
      DIV_RECIP = 3'b010,
      DIV_REM   = 3'b100
   } div_state_type;

   div_state_type            state_ff, state_in;
   logic [DVD_W-1:0]         dvd_ff, dvd_in;
   logic [DVD_W-1:0]         quot_ff, quot_in;
   logic [REM_W-1:0]         rem_ff, rem_in;
   logic [PRD_W-1:0]         prod;
   logic [DVD_W-1:0]         back;

   assign prod = PRD_W'(dvd_ff) * PRD_W'(RECIP);
   assign back = quot_ff * DIV_C;

   always_comb begin
      state_in = state_ff;
      dvd_in   = dvd_ff;
      quot_in  = quot_ff;
      rem_in   = rem_ff;
      if (start) begin
         dvd_in   = {num, {lir_pkg::FRAC_W{1'b0}}};
         state_in = DIV_RECIP;
      end else begin
         unique case (state_ff)
            DIV_IDLE: begin
               state_in = DIV_IDLE;
            end
            DIV_RECIP: begin
               quot_in  = DVD_W'(prod >> SHIFT);
               state_in = DIV_REM;
            end
            DIV_REM: begin
               rem_in   = REM_W'(dvd_ff - back);
               state_in = DIV_IDLE;
            end
            default: begin
               state_in = DIV_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= DIV_IDLE;
         dvd_ff   <= '0;
         quot_ff  <= RESET_QUOT;
         rem_ff   <= REM_W'(RESET_REM);
      end else begin
         state_ff <= state_in;
         dvd_ff   <= dvd_in;
         quot_ff  <= quot_in;
         rem_ff   <= rem_in;
      end
   end

   assign busy = state_ff != DIV_IDLE;
   assign quot = quot_ff;
   assign rem  = rem_ff;

endmodule

### hdl/lir_interp.sv
// ----------------------------------------------------------------------------
// lir_interp
// One lane of the interpolator: a + (b - a) * f / 2^16, rounded half up and
// saturated to 16 bits.
// ----------------------------------------------------------------------------
module lir_interp (
   input  logic signed [lir_pkg::SMP_W-1:0]  a,
   input  logic signed [lir_pkg::SMP_W-1:0]  b,
   input  logic        [lir_pkg::FRAC_W-1:0] f,
   output logic signed [lir_pkg::SMP_W-1:0]  y
);

   localparam int DIF_W = lir_pkg::SMP_W + 1;
   localparam int PRD_W = DIF_W + lir_pkg::FRAC_W + 1;
   localparam int SUM_W = PRD_W + 1;
   localparam int SHR_W = SUM_W - lir_pkg::FRAC_W;

   logic signed [DIF_W-1:0]  diff;
   logic signed [PRD_W-1:0]  prod;
   logic signed [SUM_W-1:0]  acc;
   logic signed [SHR_W-1:0]  shr;

   localparam logic signed [SHR_W-1:0] MAX_V = SHR_W'((1 << (lir_pkg::SMP_W-1)) - 1);
   localparam logic signed [SHR_W-1:0] MIN_V = -SHR_W'(1 << (lir_pkg::SMP_W-1));

   assign diff = DIF_W'(b) - DIF_W'(a);
   assign prod = PRD_W'(diff) * $signed({1'b0, f});
   assign acc  = (SUM_W'(a) <<< lir_pkg::FRAC_W) + SUM_W'(prod)
               + SUM_W'(1 << (lir_pkg::FRAC_W-1));
   assign shr  = SHR_W'(acc >>> lir_pkg::FRAC_W);

   always_comb begin
      if (shr > MAX_V)
         y = MAX_V[lir_pkg::SMP_W-1:0];
      else if (shr < MIN_V)
         y = MIN_V[lir_pkg::SMP_W-1:0];
      else
         y = shr[lir_pkg::SMP_W-1:0];
   end

endmodule

### hdl/linear_interp_iq_resampler.sv
// ----------------------------------------------------------------------------
// linear_interp_iq_resampler
// Block-wise linear-interpolation resampler for signed 16-bit I/Q words.
// ----------------------------------------------------------------------------
// An emitting input word passes through the interpolation stage, then the output register.
// Throughput: one input word per cycle while req_stall is low; at most one output word per input.
// A csr write reloads the step divider (lir_div), which holds req_stall high
//   while a reciprocal multiply forms the step.
// Reset: synchronous; in_per_block returns to 2500, all block state clears.
module linear_interp_iq_resampler #(
   parameter int OUT_PER_BLOCK = lir_pkg::OUT_PER_BLOCK_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_wr_en,
   input  logic [lir_pkg::CFG_W-1:0]          csr_wr_data,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic signed [lir_pkg::SMP_W-1:0]   req_sample_i,
   input  logic signed [lir_pkg::SMP_W-1:0]   req_sample_q,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic signed [lir_pkg::SMP_W-1:0]   rsp_out_i,
   output logic signed [lir_pkg::SMP_W-1:0]   rsp_out_q,
   output logic                               rsp_block_last
);

   localparam int CFG_W  = lir_pkg::CFG_W;
   localparam int SMP_W  = lir_pkg::SMP_W;
   localparam int FRAC_W = lir_pkg::FRAC_W;
   localparam int OIDX_W = lir_pkg::OIDX_W;
   localparam int DVD_W  = lir_pkg::DVD_W;
   localparam int REM_W  = $clog2(OUT_PER_BLOCK);

   localparam longint RST_DVD = longint'(lir_pkg::IN_PER_BLOCK_RST) << FRAC_W;
   localparam logic [DVD_W-1:0] RST_QUOT = DVD_W'(RST_DVD / OUT_PER_BLOCK);
   localparam int               RST_REM  = int'(RST_DVD % OUT_PER_BLOCK);

   localparam logic [REM_W:0]    D_EXT  = (REM_W+1)'(OUT_PER_BLOCK);
   localparam logic [OIDX_W-1:0] D_IDX  = OIDX_W'(OUT_PER_BLOCK);
   localparam logic [OIDX_W-1:0] D_LAST = OIDX_W'(OUT_PER_BLOCK - 1);

   // block state
   logic [CFG_W-1:0]        n_ff, n_in;
   logic [CFG_W-1:0]        pos_ff, pos_in;
   logic [OIDX_W-1:0]       oidx_ff, oidx_in;
   logic [CFG_W-1:0]        base_ff, base_in;
   logic [FRAC_W-1:0]       frac_ff, frac_in;
   logic [REM_W-1:0]        srem_ff, srem_in;
   logic signed [SMP_W-1:0] prev_i_ff, prev_i_in;
   logic signed [SMP_W-1:0] prev_q_ff, prev_q_in;

   // interpolation stage
   logic                    s1_valid_ff, s1_valid_in;
   logic signed [SMP_W-1:0] s1_a_i_ff, s1_b_i_ff, s1_a_q_ff, s1_b_q_ff;
   logic [FRAC_W-1:0]       s1_frac_ff;
   logic                    s1_last_ff;

   // output register
   logic                    rsp_valid_ff, rsp_valid_in;
   logic signed [SMP_W-1:0] rsp_i_ff, rsp_q_ff;
   logic                    rsp_last_ff;

   logic                    div_busy;
   logic [DVD_W-1:0]        div_quot;
   logic [REM_W-1:0]        div_rem;
   logic [CFG_W-1:0]        n_eff;

   logic                    accept, emit, block_end, s1_adv, s1_load;
   logic [CFG_W-1:0]        step_whole;
   logic [FRAC_W-1:0]       step_frac;
   logic [REM_W:0]          srem_sum;
   logic                    srem_carry;
   logic [REM_W-1:0]        srem_nx;
   logic [FRAC_W:0]         frac_sum;
   logic [CFG_W-1:0]        base_nx;
   logic signed [SMP_W-1:0] interp_i, interp_q;

   // a zero block length behaves as one
   assign n_eff = (csr_wr_data == '0) ? CFG_W'(1) : csr_wr_data;

   lir_div #(
      .DIVISOR    (OUT_PER_BLOCK),
      .RESET_QUOT (RST_QUOT),
      .RESET_REM  (RST_REM)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (csr_wr_en),
      .num   (n_eff),
      .busy  (div_busy),
      .quot  (div_quot),
      .rem   (div_rem)
   );

   assign step_whole = div_quot[DVD_W-1:FRAC_W];
   assign step_frac  = div_quot[FRAC_W-1:0];

   assign s1_adv    = !rsp_valid_ff || !rsp_stall;
   assign req_stall = div_busy || (s1_valid_ff && !s1_adv);
   assign accept    = req_valid && !req_stall;

   assign emit      = (pos_ff != '0) && (oidx_ff < D_IDX) && (base_ff < pos_ff);
   assign block_end = pos_ff >= n_ff;
   assign s1_load   = accept && emit;

   // weight tracked as Q0.16 plus residue below D; a weight carry moves the base
   assign srem_sum   = {1'b0, srem_ff} + {1'b0, div_rem};
   assign srem_carry = srem_sum >= D_EXT;
   assign srem_nx    = srem_carry ? REM_W'(srem_sum - D_EXT) : srem_sum[REM_W-1:0];
   assign frac_sum   = {1'b0, frac_ff} + {1'b0, step_frac} + (FRAC_W+1)'(srem_carry);
   assign base_nx    = base_ff + step_whole + CFG_W'(frac_sum[FRAC_W]);

   always_comb begin
      n_in      = n_ff;
      pos_in    = pos_ff;
      oidx_in   = oidx_ff;
      base_in   = base_ff;
      frac_in   = frac_ff;
      srem_in   = srem_ff;
      prev_i_in = prev_i_ff;
      prev_q_in = prev_q_ff;
      if (csr_wr_en)
         n_in = n_eff;
      if (accept) begin
         prev_i_in = req_sample_i;
         prev_q_in = req_sample_q;
         if (pos_ff == '0) begin
            pos_in = CFG_W'(1);
         end else begin
            if (emit) begin
               oidx_in = oidx_ff + 1'b1;
               frac_in = frac_sum[FRAC_W-1:0];
               srem_in = srem_nx;
               base_in = base_nx;
            end
            // this word closes the block and opens the next one as position 0
            if (block_end) begin
               oidx_in = '0;
               base_in = '0;
               frac_in = '0;
               srem_in = '0;
               pos_in  = CFG_W'(1);
            end else begin
               pos_in = pos_ff + 1'b1;
            end
         end
      end
   end

   always_comb begin
      if (s1_load)
         s1_valid_in = 1'b1;
      else if (s1_adv)
         s1_valid_in = 1'b0;
      else
         s1_valid_in = s1_valid_ff;
      rsp_valid_in = s1_adv ? s1_valid_ff : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         n_ff         <= CFG_W'(lir_pkg::IN_PER_BLOCK_RST);
         pos_ff       <= '0;
         oidx_ff      <= '0;
         base_ff      <= '0;
         frac_ff      <= '0;
         srem_ff      <= '0;
         prev_i_ff    <= '0;
         prev_q_ff    <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         n_ff         <= n_in;
         pos_ff       <= pos_in;
         oidx_ff      <= oidx_in;
         base_ff      <= base_in;
         frac_ff      <= frac_in;
         srem_ff      <= srem_in;
         prev_i_ff    <= prev_i_in;
         prev_q_ff    <= prev_q_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_load) begin
         s1_a_i_ff  <= prev_i_ff;
         s1_b_i_ff  <= req_sample_i;
         s1_a_q_ff  <= prev_q_ff;
         s1_b_q_ff  <= req_sample_q;
         s1_frac_ff <= frac_ff;
         s1_last_ff <= oidx_ff == D_LAST;
      end
      if (s1_adv && s1_valid_ff) begin
         rsp_i_ff    <= interp_i;
         rsp_q_ff    <= interp_q;
         rsp_last_ff <= s1_last_ff;
      end
   end

   lir_interp u_interp_i (
      .a (s1_a_i_ff),
      .b (s1_b_i_ff),
      .f (s1_frac_ff),
      .y (interp_i)
   );

   lir_interp u_interp_q (
      .a (s1_a_q_ff),
      .b (s1_b_q_ff),
      .f (s1_frac_ff),
      .y (interp_q)
   );

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_i      = rsp_i_ff;
   assign rsp_out_q      = rsp_q_ff;
   assign rsp_block_last = rsp_last_ff;

endmodule
